### rtl/vmu_pkg.sv
// ----------------------------------------------------------------------------
// Vector math unit package
// Shared widths, operation codes, pipeline payload types and the saturation
// helper used by the lanes and the merge stage.
// ----------------------------------------------------------------------------
package vmu_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned SUM_W     = PROD_W + 2;
  localparam int unsigned ROOT_W    = PROD_W / 2;
  localparam int unsigned REM_W     = ROOT_W + 3;
  localparam int unsigned QUO_W     = FRAC_BITS + 1;
  localparam int unsigned NUM_W     = DATA_W + FRAC_BITS + 1;

  typedef enum logic [1:0] {
    FUNC_MAG   = 2'd0,
    FUNC_NORM  = 2'd1,
    FUNC_DOT   = 2'd2,
    FUNC_CROSS = 2'd3
  } vmu_func_e;

  typedef logic signed [DATA_W-1:0] vmu_fix_t;

  localparam vmu_fix_t FIX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam vmu_fix_t FIX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    vmu_fix_t val;
    logic     ovf;
  } vmu_sat_t;

  // Operation and operands as they travel along the pipeline.
  typedef struct packed {
    vmu_func_e func;
    logic      aw;
    logic      bw;
    vmu_fix_t  ax;
    vmu_fix_t  ay;
    vmu_fix_t  az;
  } vmu_op_t;

  // Everything the square root and the result stage need from the front end.
  typedef struct packed {
    vmu_op_t             op;
    vmu_fix_t            dot;
    logic                dot_err;
    vmu_fix_t            cx;
    vmu_fix_t            cy;
    vmu_fix_t            cz;
    logic                crs_err;
    logic [PROD_W-1:0]   sumsq;
  } vmu_pay_t;

  typedef struct packed {
    vmu_fix_t res_x;
    vmu_fix_t res_y;
    vmu_fix_t res_z;
    vmu_fix_t scalar;
    logic     error;
  } vmu_res_t;

  // Load enables of the two front-end stages.
  typedef struct packed {
    logic mul_en;
    logic mrg_en;
  } vmu_fe_ctl_t;

  // Clamps a wide signed value to the fixed-point range.
  function automatic vmu_sat_t vmu_sat(input logic signed [SUM_W-1:0] v);
    vmu_sat_t r;
    if (v[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){v[SUM_W-1]}}) begin
      r.val = v[DATA_W-1:0];
      r.ovf = 1'b0;
    end else begin
      r.val = v[SUM_W-1] ? FIX_MIN : FIX_MAX;
      r.ovf = 1'b1;
    end
    return r;
  endfunction

endpackage

### rtl/vmu_if.sv
// ----------------------------------------------------------------------------
// Vector math unit channels
// Valid/ready channels for operation requests and for results.
// ----------------------------------------------------------------------------
interface vmu_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic signed [vmu_pkg::DATA_W-1:0]   a_x;
  logic signed [vmu_pkg::DATA_W-1:0]   a_y;
  logic signed [vmu_pkg::DATA_W-1:0]   a_z;
  logic                                a_w;
  logic signed [vmu_pkg::DATA_W-1:0]   b_x;
  logic signed [vmu_pkg::DATA_W-1:0]   b_y;
  logic signed [vmu_pkg::DATA_W-1:0]   b_z;
  logic                                b_w;

  modport source (output valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  input ready);
  modport sink (input valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                output ready);
endinterface

interface vmu_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [vmu_pkg::DATA_W-1:0]   res_x;
  logic signed [vmu_pkg::DATA_W-1:0]   res_y;
  logic signed [vmu_pkg::DATA_W-1:0]   res_z;
  logic                                res_w;
  logic signed [vmu_pkg::DATA_W-1:0]   scalar;
  logic                                error;

  modport source (output valid, res_x, res_y, res_z, res_w, scalar, error,
                  input ready);
  modport sink (input valid, res_x, res_y, res_z, res_w, scalar, error,
                output ready);
endinterface

### rtl/vmu_lane.sv
// ----------------------------------------------------------------------------
// Vector math unit lane
// Forms the square, the dot term and the two cross terms of one component,
// then the scaled and saturated cross product component.
// ----------------------------------------------------------------------------
module vmu_lane (
  input  logic                              clk_i,
  input  vmu_pkg::vmu_fe_ctl_t              ctl_i,
  input  vmu_pkg::vmu_fix_t                 a_s_i,
  input  vmu_pkg::vmu_fix_t                 b_s_i,
  input  vmu_pkg::vmu_fix_t                 a_j_i,
  input  vmu_pkg::vmu_fix_t                 b_k_i,
  input  vmu_pkg::vmu_fix_t                 a_k_i,
  input  vmu_pkg::vmu_fix_t                 b_j_i,
  output logic [vmu_pkg::PROD_W-1:0]        sq_o,
  output logic signed [vmu_pkg::PROD_W-1:0] dp_o,
  output vmu_pkg::vmu_fix_t                 crs_o,
  output logic                              crs_ovf_o
);
  import vmu_pkg::*;

  logic signed [PROD_W-1:0] sq_q, dp_q, cp_q, cq_q;
  logic signed [SUM_W-1:0]  diff, scl;
  vmu_sat_t                 crs_sat;
  vmu_fix_t                 crs_q;
  logic                     ovf_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      sq_q <= a_s_i * a_s_i;
      dp_q <= a_s_i * b_s_i;
      cp_q <= a_j_i * b_k_i;
      cq_q <= a_k_i * b_j_i;
    end
  end

  // The arithmetic shift of the exact difference is the floor of the quotient.
  always_comb begin
    diff    = SUM_W'(cp_q) - SUM_W'(cq_q);
    scl     = diff >>> FRAC_BITS;
    crs_sat = vmu_sat(scl);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mrg_en) begin
      crs_q <= crs_sat.val;
      ovf_q <= crs_sat.ovf;
    end
  end

  assign sq_o      = sq_q;
  assign dp_o      = dp_q;
  assign crs_o     = crs_q;
  assign crs_ovf_o = ovf_q;

endmodule

### rtl/vmu_merge.sv
// ----------------------------------------------------------------------------
// Vector math unit merge stage
// Sums the lane squares into the radicand and the lane products into the
// scaled, saturated dot product.
// ----------------------------------------------------------------------------
module vmu_merge (
  input  logic                              clk_i,
  input  vmu_pkg::vmu_fe_ctl_t              ctl_i,
  input  logic [vmu_pkg::PROD_W-1:0]        sq_i [3],
  input  logic signed [vmu_pkg::PROD_W-1:0] dp_i [3],
  input  logic                              aw_i,
  input  logic                              bw_i,
  output logic [vmu_pkg::PROD_W-1:0]        sumsq_o,
  output vmu_pkg::vmu_fix_t                 dot_o,
  output logic                              dot_err_o
);
  import vmu_pkg::*;

  localparam logic signed [SUM_W-1:0] FIX_ONE = SUM_W'(1) << FRAC_BITS;

  logic signed [SUM_W-1:0] dsum, dshr, dtot;
  vmu_sat_t                dsat;
  logic [PROD_W-1:0]       sumsq_q;
  vmu_fix_t                dot_q;
  logic                    err_q;

  always_comb begin
    dsum = SUM_W'(dp_i[0]) + SUM_W'(dp_i[1]) + SUM_W'(dp_i[2]);
    dshr = dsum >>> FRAC_BITS;
    // Two points contribute w times w as one unit.
    dtot = dshr + (FIX_ONE & {SUM_W{aw_i & bw_i}});
    dsat = vmu_sat(dtot);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mrg_en) begin
      sumsq_q <= sq_i[0] + sq_i[1] + sq_i[2];
      dot_q   <= dsat.val;
      err_q   <= dsat.ovf;
    end
  end

  assign sumsq_o   = sumsq_q;
  assign dot_o     = dot_q;
  assign dot_err_o = err_q;

endmodule

### rtl/vmu_sqrt.sv
// ----------------------------------------------------------------------------
// Vector math unit square root
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vmu_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  vmu_pkg::vmu_pay_t          pay_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output vmu_pkg::vmu_pay_t          pay_o,
  output logic [vmu_pkg::ROOT_W-1:0] mag_o
);
  import vmu_pkg::*;

  localparam int unsigned NST = ROOT_W;

  logic              v_q    [NST];
  logic              adv    [NST+1];
  vmu_pay_t          pay_q  [NST];
  logic [REM_W-1:0]  rem_q  [NST];
  logic [ROOT_W-1:0] root_q [NST];

  assign adv[NST] = ready_i;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    localparam int unsigned J = NST - 1 - k;

    logic              v_in;
    vmu_pay_t          pay_in;
    logic [REM_W-1:0]  rem_in, rem_sh, rem_nx;
    logic [ROOT_W-1:0] root_in, root_nx;
    logic [ROOT_W+1:0] trial;
    logic              ge;

    assign adv[k] = !v_q[k] || adv[k+1];

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign pay_in  = pay_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign pay_in  = pay_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    always_comb begin
      rem_sh  = {rem_in[REM_W-3:0], pay_in.sumsq[2*J+1 -: 2]};
      trial   = {root_in, 2'b01};
      ge      = rem_sh >= {1'b0, trial};
      rem_nx  = ge ? (rem_sh - {1'b0, trial}) : rem_sh;
      root_nx = {root_in[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        pay_q[k]  <= pay_in;
        rem_q[k]  <= rem_nx;
        root_q[k] <= root_nx;
      end
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_q[NST-1];
  assign pay_o   = pay_q[NST-1];
  assign mag_o   = root_q[NST-1];

endmodule

### rtl/vmu_norm.sv
// ----------------------------------------------------------------------------
// Vector math unit normalize and result stage
// Three restoring divider lanes, one quotient bit per stage, followed by the
// result register that selects the fields of the requested operation.
// ----------------------------------------------------------------------------
module vmu_norm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  vmu_pkg::vmu_pay_t          pay_i,
  input  logic [vmu_pkg::ROOT_W-1:0] mag_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output vmu_pkg::vmu_res_t          res_o
);
  import vmu_pkg::*;

  localparam int unsigned NDIV = QUO_W;

  logic              v_q   [NDIV+1];
  logic              adv   [NDIV+2];
  vmu_pay_t          pay_q [NDIV];
  logic [ROOT_W-1:0] mag_q [NDIV];
  logic [NUM_W-1:0]  rem_q [NDIV][3];
  logic [QUO_W-1:0]  quo_q [NDIV][3];
  vmu_res_t          res_d, res_q;
  vmu_pay_t          p;
  logic [ROOT_W-1:0] m;

  function automatic logic [NUM_W-1:0] num_of(input vmu_fix_t a);
    logic [DATA_W-1:0] mg;
    mg = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
    return NUM_W'(mg) << FRAC_BITS;
  endfunction

  // The quotient is taken on magnitudes, so the sign restores truncation
  // toward zero.
  function automatic vmu_fix_t signed_quo(input vmu_fix_t a, input logic [QUO_W-1:0] q);
    vmu_fix_t mq;
    mq = DATA_W'(q);
    return a[DATA_W-1] ? -mq : mq;
  endfunction

  assign adv[NDIV+1] = ready_i;

  for (genvar k = 0; k <= NDIV; k++) begin : g_ctl
    logic v_in;
    assign adv[k] = !v_q[k] || adv[k+1];
    if (k == 0) begin : g_first
      assign v_in = valid_i;
    end else begin : g_next
      assign v_in = v_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv[k]) begin
        v_q[k] <= v_in;
      end
    end
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    localparam int unsigned B = NDIV - 1 - k;

    vmu_pay_t          pay_in;
    logic [ROOT_W-1:0] mag_in;
    logic [NUM_W-1:0]  rem_in [3];
    logic [NUM_W-1:0]  rem_nx [3];
    logic [QUO_W-1:0]  quo_in [3];
    logic [QUO_W-1:0]  quo_nx [3];
    logic [NUM_W-1:0]  dsh;
    logic              ge [3];

    if (k == 0) begin : g_first
      always_comb begin
        pay_in    = pay_i;
        mag_in    = mag_i;
        rem_in[0] = num_of(pay_i.op.ax);
        rem_in[1] = num_of(pay_i.op.ay);
        rem_in[2] = num_of(pay_i.op.az);
        for (int l = 0; l < 3; l++) begin
          quo_in[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        pay_in = pay_q[k-1];
        mag_in = mag_q[k-1];
        for (int l = 0; l < 3; l++) begin
          rem_in[l] = rem_q[k-1][l];
          quo_in[l] = quo_q[k-1][l];
        end
      end
    end

    always_comb begin
      dsh = NUM_W'(mag_in) << B;
      for (int l = 0; l < 3; l++) begin
        ge[l]     = rem_in[l] >= dsh;
        rem_nx[l] = ge[l] ? (rem_in[l] - dsh) : rem_in[l];
        quo_nx[l] = quo_in[l] | (QUO_W'(ge[l]) << B);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        pay_q[k] <= pay_in;
        mag_q[k] <= mag_in;
        for (int l = 0; l < 3; l++) begin
          rem_q[k][l] <= rem_nx[l];
          quo_q[k][l] <= quo_nx[l];
        end
      end
    end
  end

  always_comb begin
    p     = pay_q[NDIV-1];
    m     = mag_q[NDIV-1];
    res_d = '0;
    unique case (p.op.func)
      FUNC_MAG: begin
        res_d.error = p.op.aw | m[ROOT_W-1];
        if (!p.op.aw) begin
          res_d.scalar = m[ROOT_W-1] ? FIX_MAX : vmu_fix_t'(m);
        end
      end
      FUNC_NORM: begin
        if (p.op.aw || (m == '0)) begin
          res_d.error = 1'b1;
        end else begin
          res_d.res_x = signed_quo(p.op.ax, quo_q[NDIV-1][0]);
          res_d.res_y = signed_quo(p.op.ay, quo_q[NDIV-1][1]);
          res_d.res_z = signed_quo(p.op.az, quo_q[NDIV-1][2]);
        end
      end
      FUNC_DOT: begin
        res_d.scalar = p.dot;
        res_d.error  = p.dot_err;
      end
      FUNC_CROSS: begin
        if (p.op.aw || p.op.bw) begin
          res_d.error = 1'b1;
        end else begin
          res_d.res_x = p.cx;
          res_d.res_y = p.cy;
          res_d.res_z = p.cz;
          res_d.error = p.crs_err;
        end
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[NDIV]) begin
      res_q <= res_d;
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_q[NDIV];
  assign res_o   = res_q;

endmodule

### rtl/vector3_math_unit.sv
// ----------------------------------------------------------------------------
// Vector math unit top level
// Magnitude, normalize, dot and cross product on homogeneous fixed-point
// tuples, fully pipelined.
// ----------------------------------------------------------------------------
// The unit accepts one transaction per clock while the consumer keeps up and
// returns exactly one result transaction for each, in order. It has two
// front-end stages (the three component lanes form all products, then the
// merge stage sums them and the lanes finish the cross product), 32 stages
// of the square root that produce one root bit each, and FRAC_BITS + 1
// stages of the three normalize dividers that produce one quotient bit each,
// followed by the result register. Every stage moves on as soon as the one
// after it has room, so bubbles close up and new requests keep entering
// while a finished result waits for the consumer, until every stage is full.
// Components are signed Q16.16; res_w is always zero. The error flag marks a
// point operand to magnitude, normalize or cross, a zero magnitude in
// normalize, or a saturated magnitude, dot or cross result; saturated results
// hold the clamped value, all other error cases return zero fields.
// ----------------------------------------------------------------------------
module vector3_math_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  vmu_in_if.sink     in_i,
  vmu_out_if.source  out_o
);
  import vmu_pkg::*;

  // Front-end stage registers: operation and operands of the product stage
  // and of the merge stage.
  vmu_op_t     op0_q, op1_q;
  logic        v0_q, v1_q;
  logic        adv0, adv1;
  vmu_fe_ctl_t fe_ctl;

  vmu_fix_t               a_v [3];
  vmu_fix_t               b_v [3];
  logic [PROD_W-1:0]      sq  [3];
  logic signed [PROD_W-1:0] dp [3];
  vmu_fix_t               crs [3];
  logic                   crs_ovf [3];

  logic [PROD_W-1:0] sumsq;
  vmu_fix_t          dot;
  logic              dot_err;

  vmu_pay_t          sq_pay_in, sq_pay_out;
  logic              sq_ready, sq_valid;
  logic [ROOT_W-1:0] mag;
  logic              nm_ready;
  vmu_res_t          res;

  // Each front-end stage loads when it is empty or when it hands its
  // transaction on in the same cycle.
  assign adv1          = !v1_q || sq_ready;
  assign adv0          = !v0_q || adv1;
  assign fe_ctl.mul_en = adv0;
  assign fe_ctl.mrg_en = adv1;
  assign in_i.ready    = adv0;

  assign a_v[0] = in_i.a_x;
  assign a_v[1] = in_i.a_y;
  assign a_v[2] = in_i.a_z;
  assign b_v[0] = in_i.b_x;
  assign b_v[1] = in_i.b_y;
  assign b_v[2] = in_i.b_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (adv0) begin
        v0_q <= in_i.valid;
      end
      if (adv1) begin
        v1_q <= v0_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0) begin
      op0_q.func <= vmu_func_e'(in_i.func);
      op0_q.aw   <= in_i.a_w;
      op0_q.bw   <= in_i.b_w;
      op0_q.ax   <= in_i.a_x;
      op0_q.ay   <= in_i.a_y;
      op0_q.az   <= in_i.a_z;
    end
    if (adv1) begin
      op1_q <= op0_q;
    end
  end

  // Lane l owns component l; its cross term is a_j * b_k - a_k * b_j with
  // j and k the next two components in cyclic order.
  for (genvar l = 0; l < 3; l++) begin : g_lane
    localparam int unsigned J = (l + 1) % 3;
    localparam int unsigned K = (l + 2) % 3;
    vmu_lane u_lane (
      .clk_i     (clk_i),
      .ctl_i     (fe_ctl),
      .a_s_i     (a_v[l]),
      .b_s_i     (b_v[l]),
      .a_j_i     (a_v[J]),
      .b_k_i     (b_v[K]),
      .a_k_i     (a_v[K]),
      .b_j_i     (b_v[J]),
      .sq_o      (sq[l]),
      .dp_o      (dp[l]),
      .crs_o     (crs[l]),
      .crs_ovf_o (crs_ovf[l])
    );
  end

  vmu_merge u_merge (
    .clk_i     (clk_i),
    .ctl_i     (fe_ctl),
    .sq_i      (sq),
    .dp_i      (dp),
    .aw_i      (op0_q.aw),
    .bw_i      (op0_q.bw),
    .sumsq_o   (sumsq),
    .dot_o     (dot),
    .dot_err_o (dot_err)
  );

  always_comb begin
    sq_pay_in.op      = op1_q;
    sq_pay_in.dot     = dot;
    sq_pay_in.dot_err = dot_err;
    sq_pay_in.cx      = crs[0];
    sq_pay_in.cy      = crs[1];
    sq_pay_in.cz      = crs[2];
    sq_pay_in.crs_err = crs_ovf[0] | crs_ovf[1] | crs_ovf[2];
    sq_pay_in.sumsq   = sumsq;
  end

  vmu_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .ready_o (sq_ready),
    .pay_i   (sq_pay_in),
    .valid_o (sq_valid),
    .ready_i (nm_ready),
    .pay_o   (sq_pay_out),
    .mag_o   (mag)
  );

  vmu_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .ready_o (nm_ready),
    .pay_i   (sq_pay_out),
    .mag_i   (mag),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  assign out_o.res_x  = res.res_x;
  assign out_o.res_y  = res.res_y;
  assign out_o.res_z  = res.res_z;
  assign out_o.res_w  = 1'b0;
  assign out_o.scalar = res.scalar;
  assign out_o.error  = res.error;

endmodule
